/* src/cst_pkg.sv */
// Package for the character stream tokenizer: payload structs, lexer modes,
// token kinds, keyword table and the struct passed from front to back.
// No dependencies.
`default_nettype none
package cst_pkg;

  localparam int KEYWORD_MAX_LEN = 9;
  localparam int TEXT_LEN_BITS   = 16;
  localparam int KW_COUNT        = 35;
  localparam int KW_IDX_BITS     = $clog2(KEYWORD_MAX_LEN);
  localparam int KW_LEN_BITS     = $clog2(KEYWORD_MAX_LEN + 1);
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
  localparam logic [TEXT_LEN_BITS-1:0] TEXT_MAX = '1;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;

  typedef enum logic [4:0] {
    M_IDLE, M_NUM, M_NAME, M_COMMENT, M_DISCARD,
    M_TILDE, M_LT, M_GT, M_COLON, M_AMP, M_BAR,
    M_STR, M_STR_ESC, M_CH_FIRST, M_CH_ESC, M_CH_CLOSE
  } lex_mode_t;

  typedef enum logic [6:0] {
    K_ERROR, K_EOF, K_NUM, K_NAME, K_LCURLY, K_RCURLY, K_LSQ, K_RSQ,
    K_LPAREN, K_RPAREN, K_COMMA, K_DOT, K_SEMI, K_IN, K_OUT, K_EQ,
    K_ADD, K_SUB, K_MUL, K_DIV, K_XOR, K_REM, K_AT, K_NEQ, K_NOT,
    K_LEQ, K_LSH, K_LT, K_GEQ, K_RSH, K_GT, K_ASS, K_COLON, K_LAND,
    K_AND, K_LOR, K_OR, K_STR, K_CHAR, K_KW0
  } token_kind_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [6:0]               token_kind;
    logic signed [31:0]       int_value;
    logic [TEXT_LEN_BITS-1:0] text_length;
    logic [31:0]              line_number;
    logic                     escape_error;
    logic                     last_of_run;
  } out_item_t;

  // One queue entry: up to two finished tokens from one character.
  typedef struct packed {
    logic      two;
    out_item_t tok0;
    out_item_t tok1;
  } tok_pair_t;

  typedef logic [8*KEYWORD_MAX_LEN-1:0] kw_text_t;

  function automatic kw_text_t kw_text(input int i);
    case (i)
      0: kw_text = kw_text_t'("accept");   1: kw_text = kw_text_t'("alt");
      2: kw_text = kw_text_t'("call");     3: kw_text = kw_text_t'("case");
      4: kw_text = kw_text_t'("chan");     5: kw_text = kw_text_t'("connect");
      6: kw_text = kw_text_t'("do");       7: kw_text = kw_text_t'("else");
      8: kw_text = kw_text_t'("false");    9: kw_text = kw_text_t'("final");
      10: kw_text = kw_text_t'("for");     11: kw_text = kw_text_t'("from");
      12: kw_text = kw_text_t'("function"); 13: kw_text = kw_text_t'("if");
      14: kw_text = kw_text_t'("inherits"); 15: kw_text = kw_text_t'("initial");
      16: kw_text = kw_text_t'("interface"); 17: kw_text = kw_text_t'("is");
      18: kw_text = kw_text_t'("on");      19: kw_text = kw_text_t'("par");
      20: kw_text = kw_text_t'("process"); 21: kw_text = kw_text_t'("result");
      22: kw_text = kw_text_t'("seq");     23: kw_text = kw_text_t'("server");
      24: kw_text = kw_text_t'("skip");    25: kw_text = kw_text_t'("step");
      26: kw_text = kw_text_t'("stop");    27: kw_text = kw_text_t'("then");
      28: kw_text = kw_text_t'("to");      29: kw_text = kw_text_t'("true");
      30: kw_text = kw_text_t'("until");   31: kw_text = kw_text_t'("val");
      32: kw_text = kw_text_t'("valof");   33: kw_text = kw_text_t'("var");
      default: kw_text = kw_text_t'("while");
    endcase
  endfunction

  function automatic int kw_len(input int i);
    kw_text_t t;
    int n;
    t = kw_text(i);
    n = 0;
    for (int b = 0; b < KEYWORD_MAX_LEN; b++) begin
      if (t[8*b +: 8] != 8'h00) n = b + 1;
    end
    kw_len = n;
  endfunction

endpackage
`default_nettype wire

/* src/cst_front.sv */
// Front end: accepts characters, runs the lexer state and writes the
// tokens each character completes into the queue. Uses cst_pkg.
`default_nettype none
module cst_front
  import cst_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire in_item_t  in_data,
  input  wire logic      take,
  output logic           has_tok,
  output tok_pair_t      pair
);

  lex_mode_t                mode, mode_next;
  logic [31:0]              acc, acc_next;
  logic [TEXT_LEN_BITS-1:0] tcnt, tcnt_next;
  logic [31:0]              line, line_next;
  logic [7:0]               ccode, ccode_next;
  logic                     esc, esc_next;
  logic [7:0]               kwbuf [KEYWORD_MAX_LEN];
  logic                     kw_we;
  logic [KW_IDX_BITS-1:0]   kw_wa;
  logic [7:0]               kw_wd;

  // Keyword match on the stored name; a hit gives its index.
  logic                     kw_hit;
  logic [6:0]               kw_kind;
  kw_text_t                 kwflat;

  always_comb begin
    kw_hit  = 1'b0;
    kw_kind = K_NAME;
    for (int b = 0; b < KEYWORD_MAX_LEN; b++) kwflat[8*b +: 8] = kwbuf[b];
    for (int i = 0; i < KW_COUNT; i++) begin
      kw_text_t kt;
      int       kl;
      logic     ok;
      kt = kw_text(i);
      kl = kw_len(i);
      ok = 1'b1;
      // Keyword text holds its first character in the top used byte.
      for (int b = 0; b < KEYWORD_MAX_LEN; b++) begin
        if (b < kl && kwflat[8*b +: 8] != kt[8*(kl-1-b) +: 8]) ok = 1'b0;
      end
      if (!kw_hit && ok && tcnt == TEXT_LEN_BITS'(kl)) begin
        kw_hit  = 1'b1;
        kw_kind = 7'(K_KW0 + i);
      end
    end
  end

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = c inside {["0":"9"]};
  endfunction
  function automatic logic is_letter(input logic [7:0] c);
    is_letter = c inside {["a":"z"], ["A":"Z"]};
  endfunction
  function automatic logic [7:0] dec_esc(input logic [7:0] c, output logic bad);
    bad = 1'b0;
    case (c)
      "t", "T": dec_esc = CH_TAB;
      "r", "R": dec_esc = CH_CR;
      "n", "N": dec_esc = CH_NL;
      CH_BSL, CH_SQ, CH_DQ: dec_esc = c;
      default: begin
        dec_esc = c;
        bad = 1'b1;
      end
    endcase
  endfunction

  logic [1:0]  n_tok;
  out_item_t   t0, t1;
  logic [TEXT_LEN_BITS-1:0] tinc;

  assign tinc = (tcnt == TEXT_MAX) ? tcnt : tcnt + 1'b1;

  always_comb begin
    logic [7:0] c;
    logic       redo, bad;
    logic [6:0] k;
    out_item_t  e;
    c = in_data.char_code;
    redo = 1'b0;
    bad = 1'b0;
    k = K_ERROR;
    mode_next = mode;
    acc_next = acc;
    tcnt_next = tcnt;
    line_next = line;
    ccode_next = ccode;
    esc_next = esc;
    kw_we = 1'b0;
    kw_wa = '0;
    kw_wd = c;
    n_tok = 2'd0;
    t0 = '0;
    t1 = '0;
    e = '0;
    // Tokens take the line count at the start; only a newline in the same
    // step moves it, and that never comes with a token after it.
    e.line_number = line;

    if (in_data.end_of_input) begin
      e.token_kind = K_EOF;
      t1 = e;
      n_tok = 2'd1;
      case (mode)
        M_NUM: begin
          t0 = e; t0.token_kind = K_NUM; t0.int_value = acc; n_tok = 2'd2;
        end
        M_NAME: begin
          t0 = e; n_tok = 2'd2;
          if (kw_hit) t0.token_kind = kw_kind;
          else begin
            t0.token_kind = K_NAME; t0.text_length = tcnt;
          end
        end
        M_TILDE, M_LT, M_GT, M_COLON, M_AMP, M_BAR: begin
          t0 = e; n_tok = 2'd2;
          case (mode)
            M_TILDE: t0.token_kind = K_NOT;
            M_LT:    t0.token_kind = K_LT;
            M_GT:    t0.token_kind = K_GT;
            M_COLON: t0.token_kind = K_COLON;
            M_AMP:   t0.token_kind = K_AND;
            default: t0.token_kind = K_OR;
          endcase
        end
        M_STR_ESC: begin
          t0 = e; n_tok = 2'd2; t0.token_kind = K_STR; t0.text_length = tinc;
          t0.escape_error = 1'b1; tcnt_next = tinc; esc_next = 1'b1;
        end
        M_STR: begin
          t0 = e; n_tok = 2'd2; t0.token_kind = K_STR; t0.text_length = tcnt;
          t0.escape_error = esc;
        end
        M_CH_FIRST, M_CH_ESC, M_CH_CLOSE: begin
          t0 = e; n_tok = 2'd2; t0.token_kind = K_ERROR; t0.escape_error = esc;
        end
        default: ;
      endcase
      if (n_tok == 2'd1) t0 = t1;
      mode_next = M_IDLE;
    end else begin
      case (mode)
        M_NUM: begin
          if (is_digit(c)) acc_next = (acc << 3) + (acc << 1) + 32'(c - "0");
          else begin
            t0 = e; t0.token_kind = K_NUM; t0.int_value = acc; n_tok = 2'd1;
            redo = 1'b1;
          end
        end
        M_NAME: begin
          if (is_letter(c) || is_digit(c) || c == CH_UNDER) begin
            if (tcnt < TEXT_LEN_BITS'(KEYWORD_MAX_LEN)) begin
              kw_we = 1'b1; kw_wa = KW_IDX_BITS'(tcnt);
            end
            tcnt_next = tinc;
          end else begin
            t0 = e; n_tok = 2'd1; redo = 1'b1;
            if (kw_hit) t0.token_kind = kw_kind;
            else begin
              t0.token_kind = K_NAME; t0.text_length = tcnt;
            end
          end
        end
        M_COMMENT, M_DISCARD: begin
          if (c == CH_NL) begin
            line_next = line + 1'b1; mode_next = M_IDLE;
          end
        end
        M_TILDE, M_LT, M_GT, M_COLON, M_AMP, M_BAR: begin
          if (mode == M_TILDE && c == "=") k = K_NEQ;
          else if (mode == M_LT && c == "=") k = K_LEQ;
          else if (mode == M_LT && c == "<") k = K_LSH;
          else if (mode == M_GT && c == "=") k = K_GEQ;
          else if (mode == M_GT && c == ">") k = K_RSH;
          else if (mode == M_COLON && c == "=") k = K_ASS;
          else if (mode == M_AMP && c == "&") k = K_LAND;
          else if (mode == M_BAR && c == "|") k = K_LOR;
          t0 = e; n_tok = 2'd1;
          if (k != K_ERROR) begin
            t0.token_kind = k; mode_next = M_IDLE;
          end else begin
            redo = 1'b1;
            case (mode)
              M_TILDE: t0.token_kind = K_NOT;
              M_LT:    t0.token_kind = K_LT;
              M_GT:    t0.token_kind = K_GT;
              M_COLON: t0.token_kind = K_COLON;
              M_AMP:   t0.token_kind = K_AND;
              default: t0.token_kind = K_OR;
            endcase
          end
        end
        M_STR: begin
          if (c == CH_DQ) begin
            t0 = e; n_tok = 2'd1; t0.token_kind = K_STR; t0.text_length = tcnt;
            t0.escape_error = esc; mode_next = M_IDLE;
          end else if (c == CH_BSL) mode_next = M_STR_ESC;
          else begin
            if (c == CH_NL) begin
              line_next = line + 1'b1; esc_next = 1'b1;
            end
            tcnt_next = tinc;
          end
        end
        M_STR_ESC: begin
          void'(dec_esc(c, bad));
          if (bad) esc_next = 1'b1;
          tcnt_next = tinc;
          mode_next = M_STR;
        end
        M_CH_FIRST: begin
          if (c == CH_BSL) mode_next = M_CH_ESC;
          else begin
            if (c == CH_NL) begin
              line_next = line + 1'b1; esc_next = 1'b1;
            end
            ccode_next = c; mode_next = M_CH_CLOSE;
          end
        end
        M_CH_ESC: begin
          ccode_next = dec_esc(c, bad);
          if (bad) esc_next = 1'b1;
          mode_next = M_CH_CLOSE;
        end
        M_CH_CLOSE: begin
          t0 = e; n_tok = 2'd1; t0.escape_error = esc;
          if (c == CH_SQ) begin
            t0.token_kind = K_CHAR; t0.int_value = {24'h0, ccode}; mode_next = M_IDLE;
          end else begin
            t0.token_kind = K_ERROR; redo = 1'b1;
          end
        end
        default: redo = 1'b1;
      endcase

      // Start a new token from this character.
      if (redo) begin
        mode_next = M_IDLE;
        k = K_ERROR;
        e = '0;
        e.line_number = line;
        if (is_digit(c)) begin
          acc_next = 32'(c - "0"); mode_next = M_NUM;
        end else if (is_letter(c)) begin
          kw_we = 1'b1; kw_wa = '0; tcnt_next = TEXT_LEN_BITS'(1); mode_next = M_NAME;
        end else begin
          case (c)
            CH_NL: line_next = line + 1'b1;
            CH_CR, CH_TAB, CH_SP: ;
            CH_HASH: mode_next = M_COMMENT;
            "~": mode_next = M_TILDE;
            "<": mode_next = M_LT;
            ">": mode_next = M_GT;
            ":": mode_next = M_COLON;
            "&": mode_next = M_AMP;
            "|": mode_next = M_BAR;
            CH_DQ: begin
              tcnt_next = '0; esc_next = 1'b0; mode_next = M_STR;
            end
            CH_SQ: begin
              esc_next = 1'b0; ccode_next = '0; mode_next = M_CH_FIRST;
            end
            "{": k = K_LCURLY;  "}": k = K_RCURLY;
            "[": k = K_LSQ;     "]": k = K_RSQ;
            "(": k = K_LPAREN;  ")": k = K_RPAREN;
            ",": k = K_COMMA;   ".": k = K_DOT;
            ";": k = K_SEMI;    "?": k = K_IN;
            "!": k = K_OUT;     "=": k = K_EQ;
            "+": k = K_ADD;     "-": k = K_SUB;
            "*": k = K_MUL;     "/": k = K_DIV;
            "^": k = K_XOR;     "%": k = K_REM;
            "@": k = K_AT;
            default: mode_next = M_DISCARD;
          endcase
          if (k != K_ERROR || mode_next == M_DISCARD) begin
            e.token_kind = k;
            if (n_tok == 2'd0) t0 = e;
            else t1 = e;
            n_tok = n_tok + 2'd1;
          end
        end
      end
    end
    if (n_tok == 2'd2) t1.last_of_run = 1'b1;
    else t0.last_of_run = 1'b1;
  end

  assign has_tok    = in_valid && take && n_tok != 2'd0;
  assign pair.two   = (n_tok == 2'd2);
  assign pair.tok0  = t0;
  assign pair.tok1  = t1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= M_IDLE;
      acc   <= '0;
      tcnt  <= '0;
      line  <= 32'd1;
      ccode <= '0;
      esc   <= 1'b0;
    end else if (in_valid && take) begin
      mode  <= mode_next;
      acc   <= acc_next;
      tcnt  <= tcnt_next;
      line  <= line_next;
      ccode <= ccode_next;
      esc   <= esc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && take && kw_we) kwbuf[kw_wa] <= kw_wd;
  end

  a_line_mono: assert property (@(posedge clk) disable iff (rst)
    (in_valid && take) |=> (line == $past(line) || line == $past(line) + 32'd1))
    else $error("line count moved by more than one");
  a_eof_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && take && in_data.end_of_input) |=> mode == M_IDLE)
    else $error("end mark did not return lexer to idle");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && take) |=> $stable(mode))
    else $error("lexer state moved without a beat");

endmodule
`default_nettype wire

/* src/cst_back.sv */
// Back end: token queue between lexer and output, splitting each entry of
// one or two tokens into output beats. Uses cst_pkg.
`default_nettype none
module cst_back
  import cst_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire tok_pair_t pair,
  output logic           room,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  tok_pair_t                q [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] rd, wr;
  logic [QUEUE_PTR_BITS:0]   cnt;
  logic                      half;
  logic                      pop_beat, pop_entry;

  assign room      = cnt < (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH - 1);
  assign out_valid = cnt != '0;
  assign out_data  = (q[rd].two && !half) ? q[rd].tok0 :
                     (q[rd].two ? q[rd].tok1 : q[rd].tok0);
  assign pop_beat  = out_valid && out_ready;
  assign pop_entry = pop_beat && (!q[rd].two || half);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd <= '0; wr <= '0; cnt <= '0; half <= 1'b0;
    end else begin
      if (push) wr <= wr + 1'b1;
      if (pop_entry) rd <= rd + 1'b1;
      if (pop_beat) half <= !pop_entry;
      cnt <= cnt + (QUEUE_PTR_BITS+1)'(push) - (QUEUE_PTR_BITS+1)'(pop_entry);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr] <= pair;
  end

  a_no_over: assert property (@(posedge clk) disable iff (rst)
    push |-> cnt < (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH))
    else $error("token queue overflow");
  a_half: assert property (@(posedge clk) disable iff (rst)
    half |-> (out_valid && q[rd].two))
    else $error("second half pending on a single entry");
  a_last: assert property (@(posedge clk) disable iff (rst)
    pop_entry |-> out_data.last_of_run)
    else $error("entry ends without last mark");

endmodule
`default_nettype wire

/* src/char_stream_tokenizer.sv */
// Top level of the character stream tokenizer: lexer front end and token
// queue back end. Uses cst_pkg, cst_front, cst_back.
//
// Usage: in_valid/in_ready carry one beat per source byte (char_code) or
// the end mark (end_of_input set, char_code ignored). out_valid/out_ready
// carry one token per beat; a byte yields zero, one or two tokens and the
// last of them has last_of_run set.
// Throughput: one byte per cycle while the queue has room; a byte that
// yields two tokens takes two output beats, which sets the sustained rate
// when such bytes are dense. The front end state is registered.
// A token is queued as its byte is accepted and offered after older entries.
// The four-entry queue takes up to three pending entries; in_ready drops
// when it is nearly full, so a stalled receiver holds the input off.
// Reset: lexer idle, line count one, queue empty, no output valid.
`default_nettype none
module char_stream_tokenizer
  import cst_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic      has_tok;
  tok_pair_t pair;

  cst_front u_front (
    .clk, .rst, .in_valid, .in_data, .take(in_ready), .has_tok, .pair
  );

  cst_back u_back (
    .clk, .rst, .push(has_tok), .pair, .room(in_ready), .out_valid,
    .out_ready, .out_data
  );

endmodule
`default_nettype wire

/* bench/char_stream_tokenizer_tb.sv */
// Self-checking bench for char_stream_tokenizer: directed table, then random
// token-like character streams checked against a behavioral lexer model.
// Depends on cst_pkg and the char_stream_tokenizer RTL.
`default_nettype none
module char_stream_tokenizer_tb
  import cst_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  char_stream_tokenizer i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Lexer model state
  lex_mode_t lm_mode;
  logic [31:0] lm_acc;
  logic [7:0] lm_kwbuf [KEYWORD_MAX_LEN];
  logic [TEXT_LEN_BITS-1:0] lm_count;
  logic [31:0] lm_line;
  logic [7:0] lm_chcode;
  logic lm_esc;

  out_item_t token_queue[$];
  out_item_t step_toks[$];
  int errors = 0;
  int tokens_seen = 0;
  int chars_sent = 0;

  function automatic bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_let(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  task automatic push_tok(token_kind_t k, logic [31:0] v,
                          logic [TEXT_LEN_BITS-1:0] n, logic e);
    out_item_t t;
    t.token_kind = k;
    t.int_value = v;
    t.text_length = n;
    t.line_number = lm_line;
    t.escape_error = e;
    t.last_of_run = 1'b0;
    step_toks.push_back(t);
  endtask

  task automatic bump_count();
    if (lm_count != TEXT_MAX) lm_count = lm_count + 1'b1;
  endtask

  function automatic logic [7:0] unescape(logic [7:0] c);
    case (c)
      "\\", "'", "\"": return c;
      "t", "T": return 8'd9;
      "r", "R": return 8'd13;
      "n", "N": return 8'd10;
      default: begin
        lm_esc = 1'b1;
        return c;
      end
    endcase
  endfunction

  task automatic name_done();
    kw_text_t t;
    bit hit;
    if (lm_count <= KEYWORD_MAX_LEN) begin
      for (int i = 0; i < KW_COUNT; i++) begin
        t = kw_text(i);
        if (kw_len(i) == lm_count) begin
          hit = 1'b1;
          // kw_text packs the first character in the top used byte
          for (int b = 0; b < lm_count; b++)
            if (lm_kwbuf[b] != t[8*(kw_len(i)-1-b) +: 8]) hit = 1'b0;
          if (hit) begin
            push_tok(token_kind_t'(K_KW0 + i), 0, 0, 1'b0);
            return;
          end
        end
      end
    end
    push_tok(K_NAME, 0, lm_count, 1'b0);
  endtask

  task automatic pending_single();
    case (lm_mode)
      M_TILDE: push_tok(K_NOT, 0, 0, 1'b0);
      M_LT:    push_tok(K_LT, 0, 0, 1'b0);
      M_GT:    push_tok(K_GT, 0, 0, 1'b0);
      M_COLON: push_tok(K_COLON, 0, 0, 1'b0);
      M_AMP:   push_tok(K_AND, 0, 0, 1'b0);
      default: push_tok(K_OR, 0, 0, 1'b0);
    endcase
  endtask

  task automatic start_token(logic [7:0] c);
    token_kind_t k;
    k = K_ERROR;
    lm_mode = M_IDLE;
    if (is_dig(c)) begin
      lm_acc = 32'(c - "0");
      lm_mode = M_NUM;
      return;
    end
    if (is_let(c)) begin
      lm_kwbuf[0] = c;
      lm_count = TEXT_LEN_BITS'(1);
      lm_mode = M_NAME;
      return;
    end
    case (c)
      CH_NL: begin
        lm_line++;
        return;
      end
      CH_CR, CH_TAB, CH_SP: return;
      CH_HASH: begin lm_mode = M_COMMENT; return; end
      "~": begin lm_mode = M_TILDE; return; end
      "<": begin lm_mode = M_LT; return; end
      ">": begin lm_mode = M_GT; return; end
      ":": begin lm_mode = M_COLON; return; end
      "&": begin lm_mode = M_AMP; return; end
      "|": begin lm_mode = M_BAR; return; end
      CH_DQ: begin
        lm_count = '0;
        lm_esc = 0;
        lm_mode = M_STR;
        return;
      end
      CH_SQ: begin
        lm_esc = 0;
        lm_chcode = 0;
        lm_mode = M_CH_FIRST;
        return;
      end
      "{": k = K_LCURLY;  "}": k = K_RCURLY;  "[": k = K_LSQ;  "]": k = K_RSQ;
      "(": k = K_LPAREN;  ")": k = K_RPAREN;  ",": k = K_COMMA; ".": k = K_DOT;
      ";": k = K_SEMI;    "?": k = K_IN;      "!": k = K_OUT;   "=": k = K_EQ;
      "+": k = K_ADD;     "-": k = K_SUB;     "*": k = K_MUL;   "/": k = K_DIV;
      "^": k = K_XOR;     "%": k = K_REM;     "@": k = K_AT;
      default: begin
        push_tok(K_ERROR, 0, 0, 1'b0);
        lm_mode = M_DISCARD;
        return;
      end
    endcase
    push_tok(k, 0, 0, 1'b0);
  endtask

  task automatic lex_reset();
    lm_mode = M_IDLE;
    lm_acc = 0;
    lm_count = 0;
    lm_line = 1;
    lm_chcode = 0;
    lm_esc = 0;
  endtask

  // Feed one accepted beat through the model, queue its tokens.
  task automatic lex_beat(in_item_t it);
    logic [7:0] c;
    bit redo;
    token_kind_t k;
    c = it.char_code;
    redo = 0;
    step_toks.delete();
    if (it.end_of_input) begin
      case (lm_mode)
        M_NUM: push_tok(K_NUM, lm_acc, 0, 1'b0);
        M_NAME: name_done();
        M_TILDE, M_LT, M_GT, M_COLON, M_AMP, M_BAR: pending_single();
        M_STR_ESC: begin
          lm_esc = 1;
          bump_count();
          push_tok(K_STR, 0, lm_count, 1'b1);
        end
        M_STR: push_tok(K_STR, 0, lm_count, lm_esc);
        M_CH_FIRST, M_CH_ESC, M_CH_CLOSE: push_tok(K_ERROR, 0, 0, lm_esc);
        default: ;
      endcase
      push_tok(K_EOF, 0, 0, 1'b0);
      lm_mode = M_IDLE;
    end else begin
      case (lm_mode)
        M_NUM:
          if (is_dig(c)) lm_acc = lm_acc * 10 + 32'(c - "0");
          else begin
            push_tok(K_NUM, lm_acc, 0, 1'b0);
            redo = 1;
          end
        M_NAME:
          if (is_let(c) || is_dig(c) || c == CH_UNDER) begin
            if (lm_count < KEYWORD_MAX_LEN) lm_kwbuf[lm_count] = c;
            bump_count();
          end else begin
            name_done();
            redo = 1;
          end
        M_COMMENT, M_DISCARD:
          if (c == CH_NL) begin
            lm_line++;
            lm_mode = M_IDLE;
          end
        M_TILDE, M_LT, M_GT, M_COLON, M_AMP, M_BAR: begin
          k = K_ERROR;
          if (lm_mode == M_TILDE && c == "=") k = K_NEQ;
          else if (lm_mode == M_LT && c == "=") k = K_LEQ;
          else if (lm_mode == M_LT && c == "<") k = K_LSH;
          else if (lm_mode == M_GT && c == "=") k = K_GEQ;
          else if (lm_mode == M_GT && c == ">") k = K_RSH;
          else if (lm_mode == M_COLON && c == "=") k = K_ASS;
          else if (lm_mode == M_AMP && c == "&") k = K_LAND;
          else if (lm_mode == M_BAR && c == "|") k = K_LOR;
          if (k != K_ERROR) begin
            push_tok(k, 0, 0, 1'b0);
            lm_mode = M_IDLE;
          end else begin
            pending_single();
            redo = 1;
          end
        end
        M_STR:
          if (c == CH_DQ) begin
            push_tok(K_STR, 0, lm_count, lm_esc);
            lm_mode = M_IDLE;
          end else if (c == CH_BSL) lm_mode = M_STR_ESC;
          else begin
            if (c == CH_NL) begin
              lm_line++;
              lm_esc = 1;
            end
            bump_count();
          end
        M_STR_ESC: begin
          void'(unescape(c));
          bump_count();
          lm_mode = M_STR;
        end
        M_CH_FIRST:
          if (c == CH_BSL) lm_mode = M_CH_ESC;
          else begin
            if (c == CH_NL) begin
              lm_line++;
              lm_esc = 1;
            end
            lm_chcode = c;
            lm_mode = M_CH_CLOSE;
          end
        M_CH_ESC: begin
          lm_chcode = unescape(c);
          lm_mode = M_CH_CLOSE;
        end
        M_CH_CLOSE:
          if (c == CH_SQ) begin
            push_tok(K_CHAR, {24'd0, lm_chcode}, 0, lm_esc);
            lm_mode = M_IDLE;
          end else begin
            push_tok(K_ERROR, 0, 0, lm_esc);
            redo = 1;
          end
        default: redo = 1;
      endcase
      if (redo) start_token(c);
    end
    if (step_toks.size() > 0) step_toks[$].last_of_run = 1'b1;
    foreach (step_toks[i]) token_queue.push_back(step_toks[i]);
  endtask

  // Stimulus store: items, plus a typed-in token for some directed rows
  in_item_t stim[$];
  bit stim_has_exp[$];
  out_item_t stim_exp[$];
  int stim_pos = 0;
  int model_pos = 0;

  function automatic in_item_t ch(logic [7:0] c);
    in_item_t it;
    it.char_code = c;
    it.end_of_input = 1'b0;
    return it;
  endfunction

  task automatic add_char(logic [7:0] c);
    stim.push_back(ch(c));
    stim_has_exp.push_back(0);
    stim_exp.push_back('0);
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  task automatic add_eof();
    in_item_t it;
    it.char_code = 8'($urandom);
    it.end_of_input = 1'b1;
    stim.push_back(it);
    stim_has_exp.push_back(0);
    stim_exp.push_back('0);
  endtask

  // Directed row whose single token is known by inspection.
  task automatic add_known(logic [7:0] c, token_kind_t k, logic [31:0] line);
    out_item_t t;
    t = '0;
    t.token_kind = k;
    t.line_number = line;
    t.last_of_run = 1'b1;
    stim.push_back(ch(c));
    stim_has_exp.push_back(1);
    stim_exp.push_back(t);
  endtask

  function automatic string rand_word();
    string s;
    int n;
    s = "";
    if ($urandom_range(0, 2) == 0) return kw_text_str($urandom_range(0, KW_COUNT - 1));
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 9);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: s = {s, string'(8'("A" + $urandom_range(0, 25)))};
        1: s = {s, string'(8'("0" + $urandom_range(0, 9)))};
        2: s = {s, "_"};
        default: s = {s, string'(8'("a" + $urandom_range(0, 25)))};
      endcase
      if (i == 0 && !is_let(s[0])) s[0] = "a";
    end
    return s;
  endfunction

  function automatic string kw_text_str(int i);
    kw_text_t t;
    string s;
    int n;
    t = kw_text(i);
    n = kw_len(i);
    s = "";
    for (int b = n - 1; b >= 0; b--) s = {s, string'(t[8*b +: 8])};
    return s;
  endfunction

  task automatic add_random_lexeme();
    string syms;
    string esc;
    string seconds;
    string blanks;
    int n;
    int r;
    syms = "{}[](),.;?!=+-*/^%@~<>:&|";
    esc = "\\'\"tTrRnNqx\n";
    seconds = "=<>&|";
    blanks = " \t\r\n";
    case ($urandom_range(0, 11))
      0, 1: add_str(rand_word());
      2: begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) add_char(8'("0" + $urandom_range(0, 9)));
      end
      3: add_char(syms[$urandom_range(0, syms.len() - 1)]);
      4: begin
        // start at the tilde: the pending-symbol characters sit at the end
        add_char(syms[$urandom_range(19, syms.len() - 1)]);
        add_char(seconds[$urandom_range(0, 4)]);
      end
      5: begin
        add_char(CH_DQ);
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 4) == 0) begin
            add_char(CH_BSL);
            add_char(esc[$urandom_range(0, esc.len() - 1)]);
          end else begin
            r = $urandom_range(32, 126);
            if (r == 34) r = "a";
            add_char(8'(r));
          end
        end
        if ($urandom_range(0, 7) != 0) add_char(CH_DQ);
      end
      6: begin
        add_char(CH_SQ);
        if ($urandom_range(0, 2) == 0) begin
          add_char(CH_BSL);
          add_char(esc[$urandom_range(0, esc.len() - 1)]);
        end else add_char(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 5) != 0) add_char(CH_SQ);
      end
      7: begin
        add_char(CH_HASH);
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) add_char(8'($urandom_range(0, 255)));
        add_char(CH_NL);
      end
      8: add_char(blanks[$urandom_range(0, 3)]);
      9: add_char(8'($urandom_range(0, 255)));
      10: if ($urandom_range(0, 5) == 0) add_eof(); else add_char(CH_SP);
      default: add_char(CH_SP);
    endcase
  endtask

  task automatic build_stimulus();
    // after reset: symbols and an illegal character with its discarded line
    add_known("{", K_LCURLY, 1);
    add_known("@", K_AT, 1);
    add_known(8'h00, K_ERROR, 1);
    add_char(8'hff);
    add_char(CH_NL);
    add_known(8'hff, K_ERROR, 2);
    add_char(CH_NL);
    add_str("4294967295 4294967296 ");
    add_str("while interface valof accept interfaces a_9 ");
    add_str("|x|| ~=<<>= := && ");
    add_str("\"a\\q\nb\" '\\n' '\\z' 'ab ");
    add_char(CH_DQ);
    add_char(CH_BSL);
    add_eof();
    add_char("'");
    add_eof();
    add_str("x1");
    add_eof();
    while (stim.size() < 1200) add_random_lexeme();
    add_eof();
  endtask

  initial begin
    lex_reset();
    build_stimulus();
  end

  // Sender: bursts and gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) stim_pos = stim_pos + 1;
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (stim_pos < stim.size()) begin
          in_valid <= 1'b1;
          in_data <= stim[stim_pos];
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
          end else begin
            burst_left = burst_left - 1;
            if (burst_left == 0) gap_left = ($urandom_range(0, 2) == 0) ? 0
                                              : $urandom_range(1, 6);
          end
        end else in_valid <= 1'b0;
      end
    end
  end

  // Model the accepted beats; typed-in rows double-check the model too
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      lex_beat(in_data);
      if (stim_has_exp[model_pos] && (step_toks.size() != 1 || step_toks[0] !==
          stim_exp[model_pos])) begin
        $display("%0t: directed row %0d expected %p actual model %p", $time,
                 model_pos, stim_exp[model_pos], step_toks);
        errors++;
      end
      model_pos++;
    end
  end

  // Receiver: stall pattern, one long hold-off
  int stall_cycles = 0;
  int rx_cycle = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle == 300) stall_cycles = 200;
      if (stall_cycles > 0) begin
        stall_cycles--;
        out_ready <= 1'b0;
      end else if ((rx_cycle / 64) % 3 == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Compare each token beat with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      tokens_seen++;
      if (token_queue.size() == 0) begin
        $display("%0t: unexpected token, expected none actual %p", $time, out_data);
        errors++;
      end else begin
        want = token_queue.pop_front();
        if (out_data.token_kind !== want.token_kind)
          $display("%0t: token_kind expected %0d actual %0d", $time,
                   want.token_kind, out_data.token_kind);
        if (out_data.int_value !== want.int_value)
          $display("%0t: int_value expected %0d actual %0d", $time,
                   want.int_value, out_data.int_value);
        if (out_data.text_length !== want.text_length)
          $display("%0t: text_length expected %0d actual %0d", $time,
                   want.text_length, out_data.text_length);
        if (out_data.line_number !== want.line_number)
          $display("%0t: line_number expected %0d actual %0d", $time,
                   want.line_number, out_data.line_number);
        if (out_data.escape_error !== want.escape_error)
          $display("%0t: escape_error expected %b actual %b", $time,
                   want.escape_error, out_data.escape_error);
        if (out_data.last_of_run !== want.last_of_run)
          $display("%0t: last_of_run expected %b actual %b", $time,
                   want.last_of_run, out_data.last_of_run);
        if (out_data !== want) errors++;
      end
    end
  end

  // Watchdog: cycles with no beat on either side
  int idle_run = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_run = 0;
    else idle_run++;
    if (idle_run >= 5000) begin
      $display("char_stream_tokenizer: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait (stim.size() > 0 && model_pos == stim.size());
    wait (token_queue.size() == 0);
    repeat (20) @(posedge clk);
    if (out_valid) begin
      $display("%0t: token offered after the last expected one", $time);
      errors++;
    end
    $display("Sent %0d beats (directed symbols, escapes, keywords, random streams)",
             stim.size());
    $display("Checked %0d tokens, %0d errors", tokens_seen, errors);
    if (errors == 0) begin
      $display("char_stream_tokenizer: match");
    end else begin
      $display("char_stream_tokenizer: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire
